[rtl/core/grid_quad_normal_defines.svh]
// Assertion macros shared by the grid_quad_normal RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef GRID_QUAD_NORMAL_DEFINES_SVH
`define GRID_QUAD_NORMAL_DEFINES_SVH

// Same-cycle implication.
`define GQN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gqn assertion failed");

// Next-cycle implication.
`define GQN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gqn assertion failed");

`endif

[rtl/core/gqn_pkg.sv]
// ----------------------------------------------------------------------------
// gqn_pkg
// Shared constants, types and the multiply schedule of the grid normal block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gqn_pkg;

  // Parameter defaults
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_COORD_BITS = 32;

  // Configuration registers
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] GRID_RST = 7'd16;
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Multiplier chunk width (bits of operand B per cycle)
  localparam int MUL_CH = 16;

  // Normalization widths
  localparam int NRM_BITS = 20;
  localparam int S_W      = 2 * NRM_BITS + 2;
  localparam int X_W      = S_W + NRM_BITS;
  localparam int T_W      = X_W / 2;
  localparam int NUM_SH   = 24;
  localparam int NUM_W    = NRM_BITS + NUM_SH + 1;
  localparam int Q_BITS   = 15;
  localparam int OUT_W    = 16;
  // Unit length in Q1.14; normal components saturate here.
  localparam int NRM_ONE  = 16384;

  // Edge slots
  localparam logic [1:0] E_A = 2'd0;
  localparam logic [1:0] E_B = 2'd1;
  localparam logic [1:0] E_C = 2'd2;
  localparam logic [1:0] E_D = 2'd3;

  // What happens after a product is accumulated
  localparam logic [2:0] GRP_NONE   = 3'd0;
  localparam logic [2:0] GRP_SAVE   = 3'd1;
  localparam logic [2:0] GRP_PICK_A = 3'd2;
  localparam logic [2:0] GRP_PICK_B = 3'd3;
  localparam logic [2:0] GRP_N0     = 3'd4;
  localparam logic [2:0] GRP_N1     = 3'd5;
  localparam logic [2:0] GRP_N2     = 3'd6;

  localparam int OP_W  = 5;
  localparam int N_OPS = 18;

  typedef struct packed {
    logic [1:0] ea;
    logic [1:0] ca;
    logic [1:0] eb;
    logic [1:0] cb;
    logic       neg;
    logic [2:0] grp;
  } op_t;

  // Schedule: four squared lengths, then the three cross terms.
  function automatic op_t op_info(input logic [OP_W-1:0] op);
    op_t o;
    o = '{ea: E_A, ca: 2'd0, eb: E_A, cb: 2'd0, neg: 1'b0, grp: GRP_NONE};
    unique case (op)
      5'd0:  o = '{E_A, 2'd0, E_A, 2'd0, 1'b0, GRP_NONE};
      5'd1:  o = '{E_A, 2'd1, E_A, 2'd1, 1'b0, GRP_NONE};
      5'd2:  o = '{E_A, 2'd2, E_A, 2'd2, 1'b0, GRP_SAVE};
      5'd3:  o = '{E_C, 2'd0, E_C, 2'd0, 1'b0, GRP_NONE};
      5'd4:  o = '{E_C, 2'd1, E_C, 2'd1, 1'b0, GRP_NONE};
      5'd5:  o = '{E_C, 2'd2, E_C, 2'd2, 1'b0, GRP_PICK_A};
      5'd6:  o = '{E_B, 2'd0, E_B, 2'd0, 1'b0, GRP_NONE};
      5'd7:  o = '{E_B, 2'd1, E_B, 2'd1, 1'b0, GRP_NONE};
      5'd8:  o = '{E_B, 2'd2, E_B, 2'd2, 1'b0, GRP_SAVE};
      5'd9:  o = '{E_D, 2'd0, E_D, 2'd0, 1'b0, GRP_NONE};
      5'd10: o = '{E_D, 2'd1, E_D, 2'd1, 1'b0, GRP_NONE};
      5'd11: o = '{E_D, 2'd2, E_D, 2'd2, 1'b0, GRP_PICK_B};
      5'd12: o = '{E_A, 2'd1, E_B, 2'd2, 1'b0, GRP_NONE};
      5'd13: o = '{E_A, 2'd2, E_B, 2'd1, 1'b1, GRP_N0};
      5'd14: o = '{E_A, 2'd2, E_B, 2'd0, 1'b0, GRP_NONE};
      5'd15: o = '{E_A, 2'd0, E_B, 2'd2, 1'b1, GRP_N1};
      5'd16: o = '{E_A, 2'd0, E_B, 2'd1, 1'b0, GRP_NONE};
      5'd17: o = '{E_A, 2'd1, E_B, 2'd0, 1'b1, GRP_N2};
      default: o = '{E_A, 2'd0, E_A, 2'd0, 1'b0, GRP_NONE};
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

[rtl/core/gqn_ram.sv]
// ----------------------------------------------------------------------------
// gqn_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gqn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/grid_quad_normal.sv]
// Each vertex that closes a quad passes through the chunked multiplier, a normalizing
//   shift, the bit-serial root and the bit-serial divider. A degenerate quad skips the
//   root and divider; a held output item stalls the block. A vertex that closes no quad
//   returns to idle after the line store update. One vertex is in work at a time.
// Reset (synchronous, rst_n low) sets both grid sizes to 16, counters to zero.
// ----------------------------------------------------------------------------
// grid_quad_normal
// Face normals of a micropolygon grid streamed one vertex at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "grid_quad_normal_defines.svh"

module grid_quad_normal #(
  parameter int MAX_HEIGHT = gqn_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = gqn_pkg::DEF_MAX_WIDTH,
  parameter int COORD_BITS = gqn_pkg::DEF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // pt_x, pt_y, pt_z from bit 0 up
  input  wire logic [3*COORD_BITS-1:0]      in_tdata,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // norm_x, norm_y, norm_z, quad_u, quad_v from bit 0 up, zero filled
  output logic [63:0]                       out_tdata,
  // degenerate
  output logic                              out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_addr,
  input  wire logic [gqn_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int MW    = COORD_BITS;
  localparam int DW    = MW + 1;
  localparam int TW    = 2 * MW + 3;
  localparam int NMW   = 2 * MW + 1;
  localparam int CH    = gqn_pkg::MUL_CH;
  localparam int NCH   = (MW + CH - 1) / CH;
  localparam int BPW   = NCH * CH;
  localparam int PW    = MW + BPW;
  localparam int CHW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int VW    = 3 * MW;
  localparam int DEPTH = MAX_HEIGHT + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = gqn_pkg::CFG_W;
  localparam int NRM   = gqn_pkg::NRM_BITS;
  localparam int S_W   = gqn_pkg::S_W;
  localparam int X_W   = gqn_pkg::X_W;
  localparam int T_W   = gqn_pkg::T_W;
  localparam int NUM_W = gqn_pkg::NUM_W;
  localparam int QB    = gqn_pkg::Q_BITS;
  localparam int OW    = gqn_pkg::OUT_W;
  localparam int ITW   = $clog2(T_W);
  localparam int OP_W_L = gqn_pkg::OP_W;

  localparam int E_IDX_A = 0;
  localparam int E_IDX_B = 1;
  localparam int E_IDX_C = 2;
  localparam int E_IDX_D = 3;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_ACC   = 4'd3;
  localparam logic [3:0] ST_SHIFT = 4'd4;
  localparam logic [3:0] ST_SQ    = 4'd5;
  localparam logic [3:0] ST_SQRT  = 4'd6;
  localparam logic [3:0] ST_DSET  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  // Magnitude of a signed edge component.
  function automatic logic [MW-1:0] emag(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] a;
    a = x[DW-1] ? -x : x;
    return a[MW-1:0];
  endfunction

  // Signed edge component p - q.
  function automatic logic signed [DW-1:0] ediff(input logic [MW-1:0] p,
                                                 input logic [MW-1:0] q);
    return $signed({p[MW-1], p}) - $signed({q[MW-1], q});
  endfunction

  logic [3:0]        state_r;
  logic [CW-1:0]     gw_r, gh_r, col_r, row_r, u_r, v_r;
  logic [CW-1:0]     w_eff, h_eff;
  logic [VW-1:0]     cur_r, diag_r, pv_r, rdata;
  logic signed [DW-1:0] e_r [4][3];
  logic [OP_W_L-1:0] op_r;
  logic [CHW-1:0]    ch_r;
  logic [PW-1:0]     acc_r;
  logic signed [TW-1:0] tot_r, sq_r, tot_sum;
  logic signed [TW-1:0] nr_r [2];
  logic [NMW-1:0]    m_r [3];
  logic [NMW-1:0]    m_or;
  logic [2:0]        neg_r;
  logic [1:0]        k_r;
  logic [S_W-1:0]    s_r, s_sum;
  logic [X_W-1:0]    x_r;
  logic [T_W:0]      srem_r;
  logic [T_W-1:0]    root_r;
  logic [T_W+2:0]    srem2, strial;
  logic [T_W-1:0]    drem_r;
  logic [T_W:0]      drem2;
  logic [QB-1:0]     dq_r, q_r;
  logic              q_bit;
  logic [QB-1:0]     q_raw, q_sat;
  logic [NUM_W-1:0]  num;
  logic [ITW-1:0]    it_r;
  logic [OW-1:0]     qn_r [3];
  logic              dgn_r, lq_r;
  logic [5:0]        qu_r, qv_r;
  logic              quad_w;
  gqn_pkg::op_t      opi;
  logic signed [DW-1:0] opa, opb;
  logic [MW-1:0]     maga, magb;
  logic [BPW-1:0]    bpad;
  logic [CH-1:0]     chunk;
  logic [MW+CH-1:0]  pp;
  logic              psgn;
  logic [2*MW-1:0]   prod;
  logic [NRM-1:0]    rsel;
  logic [2*NRM-1:0]  rsq;
  logic              accept, out_load;

  // Effective grid size, clamped to 1..MAX.
  always_comb begin
    w_eff = gw_r;
    if (gw_r == '0) begin
      w_eff = CW'(1);
    end else if (32'(gw_r) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end
    h_eff = gh_r;
    if (gh_r == '0) begin
      h_eff = CW'(1);
    end else if (32'(gh_r) > 32'(MAX_HEIGHT)) begin
      h_eff = CW'(MAX_HEIGHT);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign quad_w    = (u_r != '0) && (v_r != '0);

  // Line store of the previous column.
  gqn_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_line (
    .clk   (clk),
    .we    (state_r == ST_RD),
    .waddr (AW'(v_r)),
    .wdata (cur_r),
    .re    (accept),
    .raddr (AW'(row_r)),
    .rdata (rdata)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    opi   = gqn_pkg::op_info(op_r);
    opa   = e_r[opi.ea][opi.ca];
    opb   = e_r[opi.eb][opi.cb];
    maga  = emag(opa);
    magb  = emag(opb);
    psgn  = opa[DW-1] ^ opb[DW-1] ^ opi.neg;
    bpad  = BPW'(magb);
    chunk = bpad[ch_r*CH +: CH];
    pp    = maga * chunk;
    prod  = acc_r[2*MW-1:0];
    tot_sum = psgn ? (tot_r - $signed({3'b000, prod}))
                   : (tot_r + $signed({3'b000, prod}));
  end

  // Normalization helpers.
  always_comb begin
    m_or   = m_r[0] | m_r[1] | m_r[2];
    rsel   = m_r[k_r][NRM-1:0];
    rsq    = rsel * rsel;
    s_sum  = s_r + S_W'(rsq);
    srem2  = {srem_r, x_r[X_W-1 -: 2]};
    strial = (T_W+3)'({root_r, 2'b01});
    drem2  = {drem_r, dq_r[QB-1]};
    num    = (NUM_W'(rsel) << gqn_pkg::NUM_SH) + NUM_W'(root_r >> 1);
    // Quotient bit of this step and the quotient saturated at unit length.
    q_bit  = (drem2 >= {1'b0, root_r});
    q_raw  = {q_r[QB-2:0], q_bit};
    q_sat  = (q_raw > QB'(gqn_pkg::NRM_ONE)) ? QB'(gqn_pkg::NRM_ONE) : q_raw;
  end

  assign out_load = (state_r == ST_OUT) && (!out_tvalid || out_tready);

  // Control: state, grid registers, counters, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      gw_r       <= gqn_pkg::GRID_RST;
      gh_r       <= gqn_pkg::GRID_RST;
      col_r      <= '0;
      row_r      <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          gqn_pkg::REG_GRID_WIDTH:  gw_r <= cfg_wdata;
          gqn_pkg::REG_GRID_HEIGHT: gh_r <= cfg_wdata;
          default: ;
        endcase
        col_r <= '0;
        row_r <= '0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          if (!cfg_we) begin
            if (row_r >= h_eff) begin
              row_r <= '0;
              col_r <= (col_r >= w_eff) ? '0 : col_r + CW'(1);
            end else begin
              row_r <= row_r + CW'(1);
            end
          end
          state_r <= quad_w ? ST_MUL : ST_IDLE;
        end
        ST_MUL: begin
          if (ch_r == '0) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          state_r <= (op_r == OP_W_L'(gqn_pkg::N_OPS - 1)) ? ST_SHIFT : ST_MUL;
        end
        ST_SHIFT: begin
          if (m_or == '0) begin
            state_r <= ST_OUT;
          end else if (m_or[NMW-1:NRM] == '0) begin
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (k_r == 2'd2) begin
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (it_r == ITW'(T_W - 1)) begin
            state_r <= ST_DSET;
          end
        end
        ST_DSET: state_r <= ST_DIV;
        ST_DIV: begin
          if (it_r == ITW'(QB - 1)) begin
            state_r <= (k_r == 2'd2) ? ST_OUT : ST_DSET;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cur_r <= in_tdata;
          u_r   <= col_r;
          v_r   <= row_r;
        end
      end
      ST_RD: begin
        // Corners: p00 = diag, p01 = line store, p10 = previous vertex, p11 = item.
        for (int i = 0; i < 3; i++) begin
          e_r[E_IDX_A][i] <= ediff(rdata[i*MW +: MW], diag_r[i*MW +: MW]);
          e_r[E_IDX_B][i] <= ediff(pv_r[i*MW +: MW], diag_r[i*MW +: MW]);
          e_r[E_IDX_C][i] <= ediff(cur_r[i*MW +: MW], pv_r[i*MW +: MW]);
          e_r[E_IDX_D][i] <= ediff(cur_r[i*MW +: MW], rdata[i*MW +: MW]);
        end
        diag_r <= rdata;
        pv_r   <= cur_r;
        qu_r   <= 6'(u_r - CW'(1));
        qv_r   <= 6'(v_r - CW'(1));
        lq_r   <= (u_r == w_eff) && (v_r == h_eff);
        op_r   <= '0;
        ch_r   <= CHW'(NCH - 1);
        acc_r  <= '0;
        tot_r  <= '0;
        dgn_r  <= 1'b0;
      end
      ST_MUL: begin
        acc_r <= (acc_r << CH) + PW'(pp);
        if (ch_r != '0) begin
          ch_r <= ch_r - CHW'(1);
        end
      end
      ST_ACC: begin
        // The running sum restarts after every group that ends a quantity.
        tot_r <= (opi.grp == gqn_pkg::GRP_NONE) ? tot_sum : '0;
        unique case (opi.grp)
          gqn_pkg::GRP_SAVE: begin
            sq_r <= tot_sum;
          end
          gqn_pkg::GRP_PICK_A: begin
            if (tot_sum > sq_r) begin
              for (int i = 0; i < 3; i++) e_r[E_IDX_A][i] <= e_r[E_IDX_C][i];
            end
          end
          gqn_pkg::GRP_PICK_B: begin
            if (tot_sum > sq_r) begin
              for (int i = 0; i < 3; i++) e_r[E_IDX_B][i] <= e_r[E_IDX_D][i];
            end
          end
          gqn_pkg::GRP_N0: begin
            nr_r[0] <= tot_sum;
          end
          gqn_pkg::GRP_N1: begin
            nr_r[1] <= tot_sum;
          end
          gqn_pkg::GRP_N2: begin
            // Split the cross product into magnitude and sign.
            m_r[0]   <= NMW'(nr_r[0][TW-1] ? -nr_r[0] : nr_r[0]);
            m_r[1]   <= NMW'(nr_r[1][TW-1] ? -nr_r[1] : nr_r[1]);
            m_r[2]   <= NMW'(tot_sum[TW-1] ? -tot_sum : tot_sum);
            neg_r    <= {tot_sum[TW-1], nr_r[1][TW-1], nr_r[0][TW-1]};
          end
          default: ;
        endcase
        op_r  <= op_r + OP_W_L'(1);
        ch_r  <= CHW'(NCH - 1);
        acc_r <= '0;
      end
      ST_SHIFT: begin
        if (m_or == '0) begin
          dgn_r <= 1'b1;
          for (int i = 0; i < 3; i++) qn_r[i] <= '0;
        end else if (m_or[NMW-1:NRM] != '0) begin
          for (int i = 0; i < 3; i++) begin
            m_r[i] <= (m_or[NMW-1:NRM+8] != '0) ? (m_r[i] >> 8) : (m_r[i] >> 1);
          end
        end else begin
          k_r <= 2'd0;
          s_r <= '0;
        end
      end
      ST_SQ: begin
        s_r <= s_sum;
        k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        if (k_r == 2'd2) begin
          x_r    <= {s_sum, NRM'(0)};
          srem_r <= '0;
          root_r <= '0;
          it_r   <= '0;
        end
      end
      ST_SQRT: begin
        // One root bit per cycle.
        x_r  <= x_r << 2;
        it_r <= it_r + ITW'(1);
        if (srem2 >= strial) begin
          srem_r <= (T_W+1)'(srem2 - strial);
          root_r <= {root_r[T_W-2:0], 1'b1};
        end else begin
          srem_r <= (T_W+1)'(srem2);
          root_r <= {root_r[T_W-2:0], 1'b0};
        end
      end
      ST_DSET: begin
        drem_r <= T_W'(num[NUM_W-1:QB]);
        dq_r   <= num[QB-1:0];
        q_r    <= '0;
        it_r   <= '0;
      end
      ST_DIV: begin
        // One quotient bit per cycle.
        dq_r <= dq_r << 1;
        it_r <= it_r + ITW'(1);
        q_r  <= q_raw;
        if (q_bit) begin
          drem_r <= T_W'(drem2 - {1'b0, root_r});
        end else begin
          drem_r <= T_W'(drem2);
        end
        if (it_r == ITW'(QB - 1)) begin
          qn_r[k_r] <= neg_r[k_r] ? -OW'(q_sat) : OW'(q_sat);
          k_r <= k_r + 2'd1;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_tdata <= {4'b0000, qv_r, qu_r, qn_r[2], qn_r[1], qn_r[0]};
          out_tuser <= dgn_r;
          out_tlast <= lq_r;
        end
      end
      default: ;
    endcase
  end

  // Checks
  `GQN_ASSERT_NOW(a_dgn_zero, out_tvalid && out_tuser, out_tdata[47:0] == '0)
  `GQN_ASSERT_NEXT(a_acc_rd, accept, state_r == ST_RD)
  `GQN_ASSERT_NOW(a_row_bound, state_r == ST_IDLE, row_r <= h_eff && col_r <= w_eff)

endmodule

`default_nettype wire

[dv/grid_quad_normal_test.sv]
// ----------------------------------------------------------------------------
// grid_quad_normal_test
// Streams vertex grids into grid_quad_normal under several grid sizes and
// compares every face normal item against an in-bench computation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Expected face normal of one quad.
typedef struct packed {
  logic [15:0] nx;
  logic [15:0] ny;
  logic [15:0] nz;
  logic        degen;
  logic [5:0]  qu;
  logic [5:0]  qv;
  logic        last;
} face_normal_t;

// Holds the grid state, predicts the normals and checks the returned ones.
class normal_scoreboard;
  int unsigned width_reg, height_reg;
  logic [95:0] column_store [0:64];
  logic [95:0] last_vertex, corner_vertex;
  int unsigned col_idx, row_idx;
  face_normal_t pending [$];
  int errors;

  function new();
    width_reg = 16;
    height_reg = 16;
    last_vertex = '0;
    corner_vertex = '0;
    col_idx = 0;
    row_idx = 0;
    errors = 0;
    foreach (column_store[i]) column_store[i] = '0;
  endfunction

  function void set_size(bit is_height, int unsigned value);
    if (is_height) height_reg = value;
    else width_reg = value;
    col_idx = 0;
    row_idx = 0;
  endfunction

  static function int unsigned clip(int unsigned val);
    return (val < 1) ? 1 : (val > 64 ? 64 : val);
  endfunction

  // Component i of a vertex as a signed value wide enough for exact edges.
  static function logic signed [127:0] coord(logic [95:0] p, int i);
    return {{96{p[32*i+31]}}, p[32*i +: 32]};
  endfunction

  static function logic signed [127:0] sq_len(logic signed [127:0] e [3]);
    return e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
  endfunction

  static function logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  // Notes one accepted vertex and queues the normal it closes, if any.
  function void note_vertex(logic [95:0] cur);
    int unsigned gw, gh, u, v, bl, sh;
    logic [95:0] p00, p01;
    logic signed [127:0] ea [3], eb [3], ec [3], ed [3], cr [3];
    logic [127:0] mag [3], mx;
    logic [63:0] rr [3], sum, t, q;
    face_normal_t fn;
    gw = clip(width_reg);
    gh = clip(height_reg);
    u = col_idx;
    v = row_idx;
    if (u > gw) u = 0;
    if (v > gh) v = 0;
    p00 = corner_vertex;
    p01 = column_store[v];
    if (u >= 1 && v >= 1) begin
      for (int i = 0; i < 3; i++) begin
        ea[i] = coord(p01, i) - coord(p00, i);
        eb[i] = coord(last_vertex, i) - coord(p00, i);
        ec[i] = coord(cur, i) - coord(last_vertex, i);
        ed[i] = coord(cur, i) - coord(p01, i);
      end
      if (sq_len(ec) > sq_len(ea)) ea = ec;
      if (sq_len(ed) > sq_len(eb)) eb = ed;
      cr[0] = ea[1] * eb[2] - ea[2] * eb[1];
      cr[1] = ea[2] * eb[0] - ea[0] * eb[2];
      cr[2] = ea[0] * eb[1] - ea[1] * eb[0];
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = cr[i][127] ? -cr[i] : cr[i];
        if (mag[i] > mx) mx = mag[i];
      end
      fn = '0;
      if (mx == 0) begin
        fn.degen = 1'b1;
      end else begin
        bl = 0;
        for (int k = 0; k < 128; k++) if (mx[k]) bl = k + 1;
        sh = (bl > 20) ? bl - 20 : 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          rr[i] = 64'(mag[i] >> sh);
          sum += rr[i] * rr[i];
        end
        t = int_sqrt(sum << 20);
        for (int i = 0; i < 3; i++) begin
          q = ((rr[i] << 24) + (t >> 1)) / t;
          if (q > 16384) q = 16384;
          if (cr[i][127]) q = 64'h10000 - q;
          if (i == 0) fn.nx = q[15:0];
          else if (i == 1) fn.ny = q[15:0];
          else fn.nz = q[15:0];
        end
      end
      fn.qu = 6'(u - 1);
      fn.qv = 6'(v - 1);
      fn.last = (u == gw && v == gh);
      pending.push_back(fn);
    end
    corner_vertex = column_store[v];
    column_store[v] = cur;
    last_vertex = cur;
    if (v >= gh) begin
      row_idx = 0;
      col_idx = (u >= gw) ? 0 : u + 1;
    end else begin
      row_idx = v + 1;
      col_idx = u;
    end
  endfunction

  // Compares one returned normal with the oldest expectation.
  function void check_normal(face_normal_t got);
    face_normal_t exp_fn;
    if (pending.size() == 0) begin
      $display("%0t: unexpected normal item, actual %h", $time, got);
      errors++;
      return;
    end
    exp_fn = pending.pop_front();
    if (got.nx !== exp_fn.nx)
      $display("%0t: norm_x expected %h actual %h", $time, exp_fn.nx, got.nx);
    if (got.ny !== exp_fn.ny)
      $display("%0t: norm_y expected %h actual %h", $time, exp_fn.ny, got.ny);
    if (got.nz !== exp_fn.nz)
      $display("%0t: norm_z expected %h actual %h", $time, exp_fn.nz, got.nz);
    if (got.degen !== exp_fn.degen)
      $display("%0t: degenerate expected %b actual %b", $time, exp_fn.degen, got.degen);
    if (got.qu !== exp_fn.qu)
      $display("%0t: quad_u expected %0d actual %0d", $time, exp_fn.qu, got.qu);
    if (got.qv !== exp_fn.qv)
      $display("%0t: quad_v expected %0d actual %0d", $time, exp_fn.qv, got.qv);
    if (got.last !== exp_fn.last)
      $display("%0t: last_quad expected %b actual %b", $time, exp_fn.last, got.last);
    if (got !== exp_fn) errors++;
  endfunction
endclass

module grid_quad_normal_test;

  localparam int CW = gqn_pkg::CFG_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [95:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] out_tdata;
  logic out_tuser, out_tlast, out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [CW-1:0] cfg_wdata = '0;

  normal_scoreboard sb = new();
  bit long_hold = 1'b0;
  bit stall_on = 1'b1;
  bit hold_done = 1'b0;
  bit hold_now = 1'b0;

  grid_quad_normal i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver stall pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (long_hold || (stall_on && $urandom_range(0, 3) == 0)) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  // Collect accepted normal items.
  always @(posedge clk) begin
    face_normal_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.nx = out_tdata[15:0];
      got.ny = out_tdata[31:16];
      got.nz = out_tdata[47:32];
      got.qu = out_tdata[53:48];
      got.qv = out_tdata[59:54];
      got.degen = out_tuser;
      got.last = out_tlast;
      sb.check_normal(got);
    end
  end

  // Global timeout.
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  int unsigned burst_left = 0;

  // Sends one vertex, honoring bursts with random gaps.
  task automatic send_vertex(logic [95:0] vtx);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tdata <= vtx;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_vertex(vtx);
    burst_left--;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_size(logic is_height, logic [CW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= is_height ? gqn_pkg::REG_GRID_HEIGHT : gqn_pkg::REG_GRID_WIDTH;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_size(is_height, val);
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8191)) - 4096) <<< 12;
      default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  // A smooth sheet with random jitter; modes 2 and 3 give random or extreme points instead.
  function automatic logic [95:0] grid_vertex(int unsigned u, int unsigned v, int mode);
    logic [31:0] x, y, z;
    x = 32'(u) << 16;
    y = 32'(v) << 16;
    z = rand_coord(1) >>> 4;
    if (mode == 1) begin
      x = x + rand_coord(1);
      y = y + rand_coord(1);
    end else if (mode == 2) begin
      x = rand_coord(0);
      y = rand_coord(0);
      z = rand_coord(0);
    end else if (mode == 3) begin
      x = rand_coord(2);
      y = rand_coord(2);
      z = rand_coord(2);
    end
    return {z, y, x};
  endfunction

  // Streams one whole grid of the given size.
  task automatic send_grid(int unsigned gw, int unsigned gh, int mode);
    for (int unsigned u = 0; u <= gw; u++)
      for (int unsigned v = 0; v <= gh; v++)
        send_vertex(grid_vertex(u, v, mode));
  endtask

  int unsigned sent;
  int unsigned gw, gh;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a flat grid gives degenerate quads, then extremes.
    write_size(1'b0, 7'd2);
    write_size(1'b1, 7'd1);
    for (int i = 0; i < 6; i++) send_vertex('0);
    send_grid(2, 1, 3);
    drain();
    write_size(1'b0, 7'd0);
    write_size(1'b1, 7'd0);
    send_vertex({32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000});
    send_vertex({32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff});
    send_vertex({32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff});
    send_vertex({32'hffff_ffff, 32'h0000_0000, 32'h8000_0000});
    drain();

    // Out-of-range sizes clamp to the maximum; send part of one column pair.
    write_size(1'b0, 7'd127);
    write_size(1'b1, 7'd100);
    for (int i = 0; i < 70; i++) send_vertex(grid_vertex(i / 65, i % 65, 1));
    drain();

    // Random grids; one grid runs against a long receiver hold-off.
    sent = 0;
    while (sent < 1000) begin
      gw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 5);
      gh = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 5);
      if (gw * gh > 40) gw = 1;
      hold_now = !hold_done && sent > 300;
      if (hold_now) begin
        // Enough quads to fill the block while the receiver holds off.
        gw = 4;
        gh = 4;
      end
      write_size(1'b0, CW'(gw));
      write_size(1'b1, CW'(gh));
      stall_on = $urandom_range(0, 3) != 0;
      if (hold_now) begin
        hold_done = 1'b1;
        fork
          begin
            long_hold = 1'b1;
            repeat (2000) @(posedge clk);
            long_hold = 1'b0;
          end
        join_none
      end
      if (!hold_now && $urandom_range(0, 4) == 0) begin
        // Noise ends mid-grid; the next size write restarts it.
        for (int i = 0; i < $urandom_range(1, 8); i++)
          send_vertex({rand_coord(0), rand_coord(0), rand_coord(0)});
        sent += 4;
      end else begin
        send_grid(gw, gh, $urandom_range(0, 3));
        sent += (gw + 1) * (gh + 1);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
